### hw/rtl/hidx_pkg.sv
// ---------------------------------------------------------------------------
// Hash index package
// Shared constants, codes and types of the id to slot hash index.
// ---------------------------------------------------------------------------
`default_nettype none

package hidx_pkg;

	localparam int          BUCKETS_DEF = 1024;
	localparam int          SLOTS_DEF   = 256;
	localparam logic [31:0] HASH_MULT   = 32'd2654435761;

	localparam logic [1:0] OP_CLEAR  = 2'd0;
	localparam logic [1:0] OP_INSERT = 2'd1;
	localparam logic [1:0] OP_LOOKUP = 2'd2;

	localparam logic [1:0] STAT_OK     = 2'd0;
	localparam logic [1:0] STAT_MISS   = 2'd1;
	localparam logic [1:0] STAT_REJECT = 2'd2;

	typedef enum logic [2:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_HASH,
		ST_BKT_RD,
		ST_BKT_CHK,
		ST_KEY_CHK,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] found_slot;
	} result_t;

endpackage

`default_nettype wire

### hw/rtl/hidx_req_if.sv
// ---------------------------------------------------------------------------
// Hash index request channel
// Valid/ready channel that carries one operation word.
// ---------------------------------------------------------------------------
`default_nettype none

interface hidx_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  op;
	logic [31:0] key_id;
	logic [7:0]  slot_number;

	modport source (output valid, output op, output key_id, output slot_number, input ready);
	modport sink (input valid, input op, input key_id, input slot_number, output ready);
endinterface

`default_nettype wire

### hw/rtl/hidx_rsp_if.sv
// ---------------------------------------------------------------------------
// Hash index response channel
// Valid/ready channel that carries one result word.
// ---------------------------------------------------------------------------
`default_nettype none

interface hidx_rsp_if;
	logic       valid;
	logic       ready;
	logic [1:0] status;
	logic [7:0] found_slot;

	modport source (output valid, output status, output found_slot, input ready);
	modport sink (input valid, input status, input found_slot, output ready);
endinterface

`default_nettype wire

### hw/rtl/hidx_ram.sv
// ---------------------------------------------------------------------------
// Hash index RAM
// Simple dual-port synchronous RAM, one write and one registered read.
// ---------------------------------------------------------------------------
`default_nettype none

module hidx_ram #(
	parameter int WIDTH = 9,
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

### hw/rtl/hidx_ctrl.sv
// ---------------------------------------------------------------------------
// Hash index controller
// Sequences clear sweeps, inserts and lookups over the bucket and key RAMs.
// ---------------------------------------------------------------------------
`default_nettype none

module hidx_ctrl #(
	parameter int BUCKETS = hidx_pkg::BUCKETS_DEF,
	parameter int SLOTS   = hidx_pkg::SLOTS_DEF,
	localparam int BW = $clog2(BUCKETS),
	localparam int EW = $clog2(SLOTS + 1),
	localparam int SW = $clog2(SLOTS),
	localparam int CW = $clog2(BUCKETS + 1)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	hidx_req_if.sink               req,
	output logic                   res_valid,
	output hidx_pkg::result_t      res,
	input  wire logic              res_ready,
	output logic                   b_we,
	output logic [BW-1:0]          b_waddr,
	output logic [EW-1:0]          b_wdata,
	output logic [BW-1:0]          b_raddr,
	input  wire logic [EW-1:0]     b_rdata,
	output logic                   k_we,
	output logic [SW-1:0]          k_waddr,
	output logic [31:0]            k_wdata,
	output logic [SW-1:0]          k_raddr,
	input  wire logic [31:0]       k_rdata
);

	localparam logic [31:0] MULT = hidx_pkg::HASH_MULT;

	hidx_pkg::state_t state_q, state_d;

	logic [CW-1:0] count_q;
	logic [BW-1:0] clr_addr_q;
	logic          clr_pend_q;
	logic [1:0]    op_q;
	logic [31:0]   id_q;
	logic [7:0]    slot_q;
	logic [BW-1:0] bucket_q;
	logic [BW-1:0] probe_q;
	logic [7:0]    ent_q;
	logic [1:0]    status_q;
	logic [7:0]    found_q;
	logic          take;
	logic          slot_ok;
	logic          ins_ok;
	logic          b_empty;
	logic          key_hit;
	logic          last_probe;
	logic          sweep_end;

	assign take       = (state_q == hidx_pkg::ST_IDLE) && req.valid;
	assign slot_ok    = (32'(req.slot_number) < 32'(SLOTS));
	assign ins_ok     = (req.key_id != 32'd0) && slot_ok && (count_q < CW'(BUCKETS));
	assign b_empty    = (b_rdata == '0);
	assign key_hit    = (k_rdata == id_q);
	assign last_probe = (probe_q == '1);
	assign sweep_end  = (clr_addr_q == '1);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			hidx_pkg::ST_SWEEP: begin
				if (sweep_end) begin
					state_d = clr_pend_q ? hidx_pkg::ST_DONE : hidx_pkg::ST_IDLE;
				end
			end
			hidx_pkg::ST_IDLE: begin
				if (req.valid) begin
					unique case (req.op)
						hidx_pkg::OP_CLEAR:  state_d = hidx_pkg::ST_SWEEP;
						hidx_pkg::OP_INSERT: state_d = ins_ok ? hidx_pkg::ST_HASH : hidx_pkg::ST_DONE;
						hidx_pkg::OP_LOOKUP: state_d = (req.key_id != 32'd0) ?
							hidx_pkg::ST_HASH : hidx_pkg::ST_DONE;
						default:             state_d = hidx_pkg::ST_DONE;
					endcase
				end
			end
			hidx_pkg::ST_HASH:   state_d = hidx_pkg::ST_BKT_RD;
			hidx_pkg::ST_BKT_RD: state_d = hidx_pkg::ST_BKT_CHK;
			hidx_pkg::ST_BKT_CHK: begin
				if (op_q == hidx_pkg::OP_INSERT) begin
					state_d = b_empty ? hidx_pkg::ST_DONE : hidx_pkg::ST_BKT_RD;
				end else begin
					state_d = b_empty ? hidx_pkg::ST_DONE : hidx_pkg::ST_KEY_CHK;
				end
			end
			hidx_pkg::ST_KEY_CHK: begin
				state_d = (key_hit || last_probe) ? hidx_pkg::ST_DONE : hidx_pkg::ST_BKT_RD;
			end
			hidx_pkg::ST_DONE: begin
				if (res_ready) begin
					state_d = hidx_pkg::ST_IDLE;
				end
			end
			default: state_d = hidx_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		req.ready      = (state_q == hidx_pkg::ST_IDLE);
		res_valid      = (state_q == hidx_pkg::ST_DONE);
		res.status     = status_q;
		res.found_slot = found_q;
		b_we    = (state_q == hidx_pkg::ST_SWEEP) ||
		          ((state_q == hidx_pkg::ST_BKT_CHK) && (op_q == hidx_pkg::OP_INSERT) && b_empty);
		b_waddr = (state_q == hidx_pkg::ST_SWEEP) ? clr_addr_q : bucket_q;
		b_wdata = (state_q == hidx_pkg::ST_SWEEP) ? '0 : EW'(slot_q) + EW'(1);
		b_raddr = bucket_q;
		k_we    = (state_q == hidx_pkg::ST_HASH) && (op_q == hidx_pkg::OP_INSERT);
		k_waddr = SW'(slot_q);
		k_wdata = id_q;
		k_raddr = SW'(b_rdata - EW'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= hidx_pkg::ST_SWEEP;
			clr_addr_q <= '0;
			clr_pend_q <= 1'b0;
			count_q    <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == hidx_pkg::ST_SWEEP) begin
				clr_addr_q <= clr_addr_q + BW'(1);
			end
			if (take && (req.op == hidx_pkg::OP_CLEAR)) begin
				clr_pend_q <= 1'b1;
				count_q    <= '0;
			end else if (b_we && (state_q == hidx_pkg::ST_BKT_CHK)) begin
				count_q <= count_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			op_q    <= req.op;
			id_q    <= req.key_id;
			slot_q  <= req.slot_number;
			probe_q <= '0;
			found_q <= 8'd0;
			unique case (req.op)
				hidx_pkg::OP_CLEAR:  status_q <= hidx_pkg::STAT_OK;
				hidx_pkg::OP_INSERT: status_q <= ins_ok ? hidx_pkg::STAT_OK : hidx_pkg::STAT_REJECT;
				hidx_pkg::OP_LOOKUP: status_q <= hidx_pkg::STAT_MISS;
				default:             status_q <= hidx_pkg::STAT_REJECT;
			endcase
		end
		if (state_q == hidx_pkg::ST_HASH) begin
			bucket_q <= id_q[BW-1:0] * MULT[BW-1:0];
		end
		if ((state_q == hidx_pkg::ST_BKT_CHK) && !b_empty) begin
			ent_q <= 8'(b_rdata - EW'(1));
			if (op_q == hidx_pkg::OP_INSERT) begin
				bucket_q <= bucket_q + BW'(1);
			end
		end
		if (state_q == hidx_pkg::ST_KEY_CHK) begin
			if (key_hit) begin
				status_q <= hidx_pkg::STAT_OK;
				found_q  <= ent_q;
			end else begin
				probe_q  <= probe_q + BW'(1);
				bucket_q <= bucket_q + BW'(1);
			end
		end
	end

endmodule

`default_nettype wire

### hw/rtl/id_to_slot_hash_index.sv
// ---------------------------------------------------------------------------
// Id to slot hash index
// Insert writes the key RAM, then reads buckets from the hashed one on and
// writes the first empty one; lookup reads buckets and key RAM entries until
// a hit, an empty bucket or the last probe; rejects and id zero lookups go
// straight to the result. Clear sweeps the bucket RAM, one bucket write a
// cycle. A result register frees the controller for the next word unless it
// is full and rsp is stalled. After reset a sweep empties the bucket RAM first.
// ---------------------------------------------------------------------------
`default_nettype none

module id_to_slot_hash_index #(
	parameter int BUCKETS = hidx_pkg::BUCKETS_DEF,
	parameter int SLOTS   = hidx_pkg::SLOTS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	hidx_req_if.sink  req,
	hidx_rsp_if.source rsp
);

	localparam int BW = $clog2(BUCKETS);
	localparam int EW = $clog2(SLOTS + 1);
	localparam int SW = $clog2(SLOTS);

	logic              res_valid;
	logic              res_ready;
	hidx_pkg::result_t res;
	logic              b_we;
	logic [BW-1:0]     b_waddr;
	logic [EW-1:0]     b_wdata;
	logic [BW-1:0]     b_raddr;
	logic [EW-1:0]     b_rdata;
	logic              k_we;
	logic [SW-1:0]     k_waddr;
	logic [31:0]       k_wdata;
	logic [SW-1:0]     k_raddr;
	logic [31:0]       k_rdata;
	logic              out_valid_q;
	hidx_pkg::result_t out_q;

	hidx_ctrl #(
		.BUCKETS(BUCKETS),
		.SLOTS  (SLOTS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.res_valid(res_valid),
		.res      (res),
		.res_ready(res_ready),
		.b_we     (b_we),
		.b_waddr  (b_waddr),
		.b_wdata  (b_wdata),
		.b_raddr  (b_raddr),
		.b_rdata  (b_rdata),
		.k_we     (k_we),
		.k_waddr  (k_waddr),
		.k_wdata  (k_wdata),
		.k_raddr  (k_raddr),
		.k_rdata  (k_rdata)
	);

	hidx_ram #(
		.WIDTH(EW),
		.DEPTH(BUCKETS)
	) u_bucket_ram (
		.clk  (clk),
		.we   (b_we),
		.waddr(b_waddr),
		.wdata(b_wdata),
		.raddr(b_raddr),
		.rdata(b_rdata)
	);

	hidx_ram #(
		.WIDTH(32),
		.DEPTH(SLOTS)
	) u_key_ram (
		.clk  (clk),
		.we   (k_we),
		.waddr(k_waddr),
		.wdata(k_wdata),
		.raddr(k_raddr),
		.rdata(k_rdata)
	);

	assign res_ready = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.status     = out_q.status;
	assign rsp.found_slot = out_q.found_slot;

endmodule

`default_nettype wire
